/* hdl/framed_link_deframer_unit_macros.svh */
// ----------------------------------------------------------------------------
// framed_link_deframer_unit_macros
// Assertion macros for the frame deframer.
// ----------------------------------------------------------------------------
`ifndef FRAMED_LINK_DEFRAMER_UNIT_MACROS_SVH
`define FRAMED_LINK_DEFRAMER_UNIT_MACROS_SVH

// Condition holds in the same cycle as its trigger.
`define FLD_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("deframer check failed");

// Condition holds in the cycle after its trigger.
`define FLD_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("deframer check failed");

`endif

/* hdl/fld_pkg.sv */
// ----------------------------------------------------------------------------
// fld_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package fld_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'h68;
  localparam logic [7:0] STOP_BYTE  = 8'h16;
  localparam logic [8:0] HEAD_BYTES = 9'd4;
  localparam logic [8:0] PRE_BODY   = 9'd7;
  localparam logic [8:0] TAIL_BYTES = 9'd3;

  localparam logic [2:0] KIND_BODY     = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_BAD_SUM  = 3'd2;
  localparam logic [2:0] KIND_NO_STOP  = 3'd3;
  localparam logic [2:0] KIND_OVERFLOW = 3'd4;

  typedef struct packed {
    logic        hunting;
    logic        header_valid;
    logic [8:0]  bytes_seen;
    logic [8:0]  frame_total;
    logic [7:0]  length_first;
    logic [7:0]  length_second;
    logic [15:0] running_sum;
    logic [7:0]  tail_low;
    logic [7:0]  tail_high;
    logic [9:0]  fill_level;
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [8:0] index;
  } result_t;

  localparam state_t STATE_RESET = '{
    hunting:       1'b1,
    header_valid:  1'b0,
    bytes_seen:    9'd0,
    frame_total:   9'd0,
    length_first:  8'd0,
    length_second: 8'd0,
    running_sum:   16'd0,
    tail_low:      8'd0,
    tail_high:     8'd0,
    fill_level:    10'd0
  };

endpackage

/* hdl/fld_core.sv */
// ----------------------------------------------------------------------------
// fld_core
// Per-byte frame logic: next state and optional result for one received byte.
// ----------------------------------------------------------------------------
module fld_core #(
  parameter int BUFFER_BYTES = 512
) (
  input  fld_pkg::state_t  cur,
  input  logic [7:0]       rx,
  output fld_pkg::state_t  nxt,
  output fld_pkg::result_t res,
  output logic             res_valid
);

  localparam logic [10:0] BUF_LIMIT = 11'(BUFFER_BYTES);

  logic [10:0] fill_inc;
  logic [8:0]  done;
  logic [9:0]  seen_w;
  logic [9:0]  total_w;
  logic [15:0] tail;

  assign fill_inc = {1'b0, cur.fill_level} + 11'd1;

  always_comb begin
    nxt       = cur;
    res       = '0;
    res_valid = 1'b0;
    done      = '0;
    seen_w    = '0;
    total_w   = '0;
    tail      = {cur.tail_high, cur.tail_low};

    // buffer would fill: abandon any frame in progress
    if (fill_inc >= BUF_LIMIT) begin
      if (!nxt.hunting) begin
        if (nxt.header_valid && nxt.bytes_seen > fld_pkg::HEAD_BYTES) begin
          done = nxt.bytes_seen - fld_pkg::HEAD_BYTES;
          if (nxt.frame_total >= fld_pkg::PRE_BODY &&
              done > nxt.frame_total - fld_pkg::PRE_BODY) begin
            done = nxt.frame_total - fld_pkg::PRE_BODY;
          end
        end
        res.kind  = fld_pkg::KIND_OVERFLOW;
        res.index = done;
        res_valid = 1'b1;
      end
      nxt.hunting    = 1'b1;
      nxt.fill_level = '0;
    end

    if (nxt.hunting) begin
      if (rx == fld_pkg::SYNC_BYTE) begin
        nxt.bytes_seen   = 9'd1;
        nxt.header_valid = 1'b0;
        nxt.hunting      = 1'b0;
        nxt.running_sum  = '0;
      end
    end else begin
      nxt.bytes_seen = nxt.bytes_seen + 9'd1;
      seen_w  = {1'b0, nxt.bytes_seen};
      total_w = {1'b0, nxt.frame_total};
      if (nxt.bytes_seen == 9'd2) begin
        nxt.length_first = rx;
      end else if (nxt.bytes_seen == 9'd3) begin
        nxt.length_second = rx;
      end else if (nxt.bytes_seen >= fld_pkg::HEAD_BYTES) begin
        if (!nxt.header_valid) begin
          if (rx == fld_pkg::SYNC_BYTE && nxt.length_first == nxt.length_second) begin
            nxt.frame_total  = fld_pkg::HEAD_BYTES + fld_pkg::PRE_BODY
                             + {1'b0, nxt.length_first} + fld_pkg::TAIL_BYTES;
            nxt.header_valid = 1'b1;
          end else begin
            nxt.hunting = 1'b1;
          end
        end else if (seen_w == total_w) begin
          res.index = nxt.frame_total - fld_pkg::PRE_BODY;
          if (rx == fld_pkg::STOP_BYTE) begin
            res.kind = (nxt.running_sum == tail) ? fld_pkg::KIND_GOOD
                                                 : fld_pkg::KIND_BAD_SUM;
          end else begin
            res.kind = fld_pkg::KIND_NO_STOP;
          end
          res_valid   = 1'b1;
          nxt.hunting = 1'b1;
        end else if (seen_w + 10'd2 == total_w) begin
          nxt.tail_low = rx;
        end else if (seen_w + 10'd1 == total_w) begin
          nxt.tail_high = rx;
        end else if (seen_w + 10'd2 < total_w) begin
          nxt.running_sum = nxt.running_sum + {8'd0, rx};
          res.kind  = fld_pkg::KIND_BODY;
          res.data  = rx;
          res.index = nxt.bytes_seen - fld_pkg::HEAD_BYTES - 9'd1;
          res_valid = 1'b1;
        end
      end
    end

    nxt.fill_level = nxt.hunting ? 10'd0 : nxt.fill_level + 10'd1;
  end

endmodule

/* hdl/fld_out_stage.sv */
// ----------------------------------------------------------------------------
// fld_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module fld_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fld_pkg::result_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output fld_pkg::result_t res_q,
  output logic             free
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

/* hdl/framed_link_deframer_unit.sv */
// ----------------------------------------------------------------------------
// framed_link_deframer_unit
// Frame deframer: sync/length header check, body pass-through, 16-bit
// additive checksum and stop byte check with one verdict per frame.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   input     in_valid / in_ready    rx_byte
//   output    out_valid / out_ready  result_kind, body_byte, body_index
//
// One byte a cycle sustained while the output is not stalled; a beat taken
// goes to the input register, then to the state update and result load.
// The running sum and counters are computed combinationally from the state register.
// Synchronous reset returns to hunting for sync with the buffer empty.
// A stalled output holds the input register; in_ready drops only then.
module framed_link_deframer_unit #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] result_kind,
  output logic [7:0] body_byte,
  output logic [8:0] body_index
);

`include "framed_link_deframer_unit_macros.svh"

  logic             in_full;
  logic [7:0]       in_byte;
  logic             fire;
  logic             free;
  fld_pkg::state_t  state;
  fld_pkg::state_t  state_next;
  fld_pkg::result_t res;
  fld_pkg::result_t res_q;
  logic             res_valid;

  assign fire     = in_full && free;
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  fld_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .cur       (state),
    .rx        (in_byte),
    .nxt       (state_next),
    .res       (res),
    .res_valid (res_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fld_pkg::STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  fld_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q),
    .free      (free)
  );

  assign result_kind = res_q.kind;
  assign body_byte   = res_q.data;
  assign body_index  = res_q.index;

  // while hunting nothing is buffered
  `FLD_ASSERT_SAME(a_hunt_empty, clk, rst, state.hunting, state.fill_level == 10'd0)
  // an accepted header keeps the byte count short of the frame end
  `FLD_ASSERT_SAME(a_seen_bound, clk, rst, !state.hunting && state.header_valid,
                   state.bytes_seen < state.frame_total)
  // a verdict sends the block back to hunting (an overflow on a sync byte starts a new frame)
  `FLD_ASSERT_NEXT(a_verdict_hunt, clk, rst,
                   fire && res_valid && res.kind != fld_pkg::KIND_BODY, state.hunting)
  // verdicts carry no body byte
  `FLD_ASSERT_SAME(a_verdict_zero, clk, rst,
                   out_valid && result_kind != fld_pkg::KIND_BODY, body_byte == 8'd0)

endmodule

/* dv/framed_link_deframer_unit_tb.sv */
// ----------------------------------------------------------------------------
// framed_link_deframer_unit_tb
// Self-checking bench for the frame deframer. A short directed sequence
// covers a good frame, a length mismatch and a wrong fourth header byte. It is
// followed by random frames: good, bad checksum, missing stop, broken header
// and line noise, with bursts of idle on both channels. Every result beat is
// checked field by field against its directed row or the in-bench deframer model.
// ----------------------------------------------------------------------------
module framed_link_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_BYTES       = 512;
  localparam int N_ITEMS         = 1700;
  localparam int CALM_BEATS      = 300;
  localparam int WATCHDOG_CYCLES = 500;
  localparam int SETTLE_CYCLES   = 20;
  localparam int MAX_PRINTED     = 40;

  // how a directed row is checked
  localparam logic [1:0] ROW_NONE  = 2'd0;  // no result
  localparam logic [1:0] ROW_TYPED = 2'd1;  // result given in the row
  localparam logic [1:0] ROW_MODEL = 2'd2;  // result from the model

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [8:0] idx;
  } deframe_out_t;

  typedef struct packed {
    logic [7:0]   b;
    logic [1:0]   mode;
    deframe_out_t want;
  } dir_row_t;

  localparam deframe_out_t NO_OUT = '0;
  localparam int DIR_N = 24;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // good frame, len 0: body FF 00 01 80 7F FF 55, sum 0x0353
    '{fld_pkg::SYNC_BYTE, ROW_NONE,  NO_OUT},
    '{8'h00,              ROW_NONE,  NO_OUT},
    '{8'h00,              ROW_NONE,  NO_OUT},
    '{fld_pkg::SYNC_BYTE, ROW_NONE,  NO_OUT},
    '{8'hFF,              ROW_TYPED, '{fld_pkg::KIND_BODY, 8'hFF, 9'd0}},
    '{8'h00,              ROW_TYPED, '{fld_pkg::KIND_BODY, 8'h00, 9'd1}},
    '{8'h01,              ROW_TYPED, '{fld_pkg::KIND_BODY, 8'h01, 9'd2}},
    '{8'h80,              ROW_TYPED, '{fld_pkg::KIND_BODY, 8'h80, 9'd3}},
    '{8'h7F,              ROW_TYPED, '{fld_pkg::KIND_BODY, 8'h7F, 9'd4}},
    '{8'hFF,              ROW_TYPED, '{fld_pkg::KIND_BODY, 8'hFF, 9'd5}},
    '{8'h55,              ROW_TYPED, '{fld_pkg::KIND_BODY, 8'h55, 9'd6}},
    '{8'h53,              ROW_MODEL, NO_OUT},
    '{8'h03,              ROW_MODEL, NO_OUT},
    '{fld_pkg::STOP_BYTE, ROW_TYPED, '{fld_pkg::KIND_GOOD, 8'h00, 9'd7}},
    // lengths differ; the closing 0x68 must not restart the hunt
    '{fld_pkg::SYNC_BYTE, ROW_NONE,  NO_OUT},
    '{8'h01,              ROW_NONE,  NO_OUT},
    '{8'h02,              ROW_NONE,  NO_OUT},
    '{fld_pkg::SYNC_BYTE, ROW_NONE,  NO_OUT},
    // would be a valid header (and body beats) had that 0x68 been taken
    '{8'h01,              ROW_NONE,  NO_OUT},
    '{8'h01,              ROW_NONE,  NO_OUT},
    '{fld_pkg::SYNC_BYTE, ROW_NONE,  NO_OUT},
    '{8'hFF,              ROW_NONE,  NO_OUT},
    '{8'hFF,              ROW_NONE,  NO_OUT},
    '{8'hFF,              ROW_NONE,  NO_OUT}   // fourth header byte not 0x68
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] result_kind;
  logic [7:0] body_byte;
  logic [8:0] body_index;

  framed_link_deframer_unit #(.BUFFER_BYTES(BUF_BYTES)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .body_byte   (body_byte),
    .body_index  (body_index)
  );

  always #5 clk = ~clk;

  // deframer model state, at its reset values
  logic        hunt            = 1'b1;
  logic        hdr_ok          = 1'b0;
  logic [8:0]  seen_cnt        = '0;
  logic [8:0]  frame_len_total = '0;
  logic [7:0]  len_a           = '0;
  logic [7:0]  len_b           = '0;
  logic [15:0] sum16           = '0;
  logic [7:0]  tail_lo         = '0;
  logic [7:0]  tail_hi         = '0;
  logic [9:0]  buf_fill        = '0;

  deframe_out_t pending_out[$];
  int  err_cnt    = 0;
  int  idle_cycles = 0;
  int  stall_left  = 0;
  bit  tx_gappy    = 1'b0;
  bit  rx_gappy    = 1'b0;

  function automatic bit deframe_byte(input logic [7:0] b, output deframe_out_t r);
    bit         got;
    logic [8:0] done;
    got = 1'b0;
    r   = NO_OUT;
    if (buf_fill + 1 >= BUF_BYTES) begin
      if (!hunt) begin
        done = '0;
        if (hdr_ok && seen_cnt > fld_pkg::HEAD_BYTES) begin
          done = seen_cnt - fld_pkg::HEAD_BYTES;
          if (frame_len_total >= fld_pkg::PRE_BODY &&
              done > frame_len_total - fld_pkg::PRE_BODY)
            done = frame_len_total - fld_pkg::PRE_BODY;
        end
        r   = '{fld_pkg::KIND_OVERFLOW, 8'd0, done};
        got = 1'b1;
      end
      hunt     = 1'b1;
      buf_fill = '0;
    end
    if (hunt) begin
      if (b == fld_pkg::SYNC_BYTE) begin
        seen_cnt = 9'd1;
        hdr_ok   = 1'b0;
        hunt     = 1'b0;
        sum16    = '0;
      end
    end else begin
      seen_cnt = seen_cnt + 9'd1;
      if (seen_cnt == 2) begin
        len_a = b;
      end else if (seen_cnt == 3) begin
        len_b = b;
      end else if (seen_cnt >= fld_pkg::HEAD_BYTES) begin
        if (!hdr_ok) begin
          if (b == fld_pkg::SYNC_BYTE && len_a == len_b) begin
            frame_len_total = fld_pkg::HEAD_BYTES + fld_pkg::PRE_BODY
                            + fld_pkg::TAIL_BYTES + len_a;
            hdr_ok = 1'b1;
          end else begin
            hunt = 1'b1;
          end
        end else if (seen_cnt == frame_len_total) begin
          if (b == fld_pkg::STOP_BYTE)
            r = '{(sum16 == {tail_hi, tail_lo}) ? fld_pkg::KIND_GOOD
                                                 : fld_pkg::KIND_BAD_SUM,
                  8'd0, frame_len_total - fld_pkg::PRE_BODY};
          else
            r = '{fld_pkg::KIND_NO_STOP, 8'd0, frame_len_total - fld_pkg::PRE_BODY};
          got  = 1'b1;
          hunt = 1'b1;
        end else if (seen_cnt + 2 == frame_len_total) begin
          tail_lo = b;
        end else if (seen_cnt + 1 == frame_len_total) begin
          tail_hi = b;
        end else if (seen_cnt + 2 < frame_len_total) begin
          sum16 = sum16 + b;
          r     = '{fld_pkg::KIND_BODY, b, seen_cnt - fld_pkg::HEAD_BYTES - 9'd1};
          got   = 1'b1;
        end
      end
    end
    if (hunt)
      buf_fill = '0;
    else
      buf_fill = buf_fill + 10'd1;
    return got;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTED)
      $display("%0t: mismatch: %s", $time, what);
  endtask

  // Drives one beat, waits for it to be taken, then records what it should give.
  task automatic send_beat(input logic [7:0] b, input logic [1:0] mode,
                           input deframe_out_t want);
    deframe_out_t r;
    bit           got;
    if (tx_gappy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    got = deframe_byte(b, r);
    case (mode)
      ROW_MODEL: if (got) pending_out.push_back(r);
      ROW_TYPED: pending_out.push_back(want);
      default: ;
    endcase
  endtask

  // result side: random stall bursts, and the check of every result beat
  always @(posedge clk) begin
    deframe_out_t want;
    if (rst) begin
      out_ready <= 1'b1;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_out.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %0h index %0d",
                                    result_kind, body_byte, body_index));
        end else begin
          want = pending_out.pop_front();
          if (result_kind !== want.kind)
            report_mismatch($sformatf("result_kind got %0d want %0d",
                                      result_kind, want.kind));
          if (body_byte !== want.data)
            report_mismatch($sformatf("body_byte got %0h want %0h", body_byte, want.data));
          if (body_index !== want.idx)
            report_mismatch($sformatf("body_index got %0d want %0d",
                                      body_index, want.idx));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (rx_gappy && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 8);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat taken on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("watchdog: no beat taken for %0d cycles", WATCHDOG_CYCLES);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0]  beats[$];
    logic [7:0]  flen;
    logic [7:0]  bb;
    logic [7:0]  stop;
    logic [15:0] csum;
    int          pick;
    int          lsel;
    int          frame_no;
    int          frame_beats;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i])
      send_beat(DIR_ROWS[i].b, DIR_ROWS[i].mode, DIR_ROWS[i].want);

    frame_no    = 0;
    frame_beats = 0;
    while (frame_beats < N_ITEMS) begin
      if (frame_beats >= N_ITEMS - CALM_BEATS) begin
        tx_gappy = 1'b0;
        rx_gappy = 1'b0;
      end else if (frame_no % 6 < 4) begin
        tx_gappy = $urandom_range(0, 2) != 0;
        rx_gappy = $urandom_range(0, 2) != 0;
      end else begin
        tx_gappy = 1'b0;
        rx_gappy = 1'b0;
      end

      pick = $urandom_range(0, 99);
      lsel = $urandom_range(0, 99);
      // mostly short frames, now and then a long or a full-length one
      if (lsel < 2)
        flen = 8'hFF;
      else if (lsel < 8)
        flen = 8'($urandom_range(0, 255));
      else
        flen = 8'($urandom_range(0, 12));

      beats.delete();
      if (pick >= 88) begin
        // line noise, any byte value
        repeat ($urandom_range(1, 6)) beats.push_back(8'($urandom));
      end else begin
        beats.push_back(fld_pkg::SYNC_BYTE);
        beats.push_back(flen);
        beats.push_back(flen);
        beats.push_back(fld_pkg::SYNC_BYTE);
        if (pick >= 80) begin
          if ($urandom_range(0, 1) == 1)
            beats[2] = flen ^ 8'($urandom_range(1, 255));
          else
            do beats[3] = 8'($urandom); while (beats[3] == fld_pkg::SYNC_BYTE);
        end else begin
          csum = '0;
          for (int i = 0; i < int'(flen) + 7; i++) begin
            bb   = 8'($urandom);
            csum = csum + bb;
            beats.push_back(bb);
          end
          if (pick >= 55 && pick < 70)
            csum = csum + 16'($urandom_range(1, 65535));
          beats.push_back(csum[7:0]);
          beats.push_back(csum[15:8]);
          stop = fld_pkg::STOP_BYTE;
          if (pick >= 70)
            while (stop == fld_pkg::STOP_BYTE) stop = 8'($urandom);
          beats.push_back(stop);
        end
        frame_beats += beats.size();
      end

      foreach (beats[i])
        send_beat(beats[i], ROW_MODEL, NO_OUT);

      // hold the sender off until the block has caught up
      if (frame_no % 15 == 7) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_out.size() != 0);
      end
      frame_no++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_out.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
